FILE: rtl/cds_pkg.sv
// cds_pkg: types and constants shared by the c-scan request scheduler
// used by cds_front, cds_fifo, cds_back and cscan_disk_request_scheduler
package cds_pkg;

	localparam int MAX_REQUESTS = 16;
	localparam int TRACK_BITS   = 12;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W        = $clog2(MAX_REQUESTS);
	localparam int MOVE_W       = 14;
	localparam int SEEK_W       = 18;
	localparam int DISK_W       = 13;
	localparam int SPT_W        = 4;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [MOVE_W-1:0]     MOVE_MAX  = {MOVE_W{1'b1}};
	localparam logic [TRACK_BITS-1:0] TRACK_MAX = {TRACK_BITS{1'b1}};

	// register indexes
	localparam logic [1:0] REG_START_POSITION = 2'd0;
	localparam logic [1:0] REG_DISK_TRACKS    = 2'd1;
	localparam logic [1:0] REG_SEEK_PER_TRACK = 2'd2;

	typedef struct packed {
		logic [11:0] request_track;
		logic        last_request;
	} req_t;

	typedef struct packed {
		logic [11:0]       served_track;
		logic              is_disk_end;
		logic [MOVE_W-1:0] total_movement;
		logic [SEEK_W-1:0] seek_time;
		logic              overflow;
		logic              final_item;
	} res_t;

	typedef struct packed {
		logic [11:0]       start_position;
		logic [DISK_W-1:0] disk_tracks;
		logic [SPT_W-1:0]  seek_per_track;
	} cfg_t;

	typedef struct packed {
		logic [TRACK_BITS-1:0] track;
		logic                  is_end;
		logic                  last;
		logic                  overflow;
	} qent_t;

endpackage

FILE: rtl/cds_front.sv
// cds_front: sorted insertion store for requests and the c-scan order walk
// depends on cds_pkg; pushes visits into cds_fifo
module cds_front (
	input  logic          clk,
	input  logic          arst_n,
	input  cds_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  cds_pkg::req_t in_data,
	output logic          q_push,
	output cds_pkg::qent_t q_data,
	input  logic          q_full
);

	typedef enum logic [1:0] {LOAD, PASS1, DEND, PASS2} state_t;

	state_t                                state_q;
	logic [cds_pkg::CNT_W-1:0]             count_q;
	logic [cds_pkg::CNT_W-1:0]             idx_q;
	logic [cds_pkg::CNT_W-1:0]             lo_q;
	logic                                  drop_q;
	logic                                  ovf_q;
	logic [cds_pkg::TRACK_BITS-1:0]        store_q [cds_pkg::MAX_REQUESTS];

	logic                                  accept;
	logic                                  store_full;
	logic [cds_pkg::TRACK_BITS-1:0]        t;
	logic [cds_pkg::MAX_REQUESTS-1:0]      gt;
	logic [cds_pkg::MAX_REQUESTS-1:0]      wr;
	logic [cds_pkg::TRACK_BITS-1:0]        nxt [cds_pkg::MAX_REQUESTS];
	logic [cds_pkg::TRACK_BITS-1:0]        rd;
	logic [cds_pkg::DISK_W-1:0]            end_m1;
	logic [cds_pkg::TRACK_BITS-1:0]        end_trk;

	assign in_stall   = (state_q != LOAD);
	assign accept     = in_valid && (state_q == LOAD);
	assign store_full = (count_q == cds_pkg::CNT_W'(cds_pkg::MAX_REQUESTS));
	assign t          = in_data.request_track[cds_pkg::TRACK_BITS-1:0];
	assign rd         = store_q[idx_q[cds_pkg::IDX_W-1:0]];

	// insertion: entries above the new track move up by one
	always_comb begin
		for (int j = 0; j < cds_pkg::MAX_REQUESTS; j++) begin
			gt[j] = (cds_pkg::CNT_W'(j) < count_q) && (store_q[j] > t);
		end
		nxt[0] = t;
		wr[0]  = gt[0] || (count_q == '0);
		for (int j = 1; j < cds_pkg::MAX_REQUESTS; j++) begin
			nxt[j] = gt[j-1] ? store_q[j-1] : t;
			wr[j]  = gt[j] || (cds_pkg::CNT_W'(j) == count_q);
		end
	end

	always_comb begin
		end_m1 = cfg.disk_tracks - cds_pkg::DISK_W'(1);
		if (cfg.disk_tracks == '0) begin
			end_trk = '0;
		end else if (end_m1 > cds_pkg::DISK_W'(cds_pkg::TRACK_MAX)) begin
			end_trk = cds_pkg::TRACK_MAX;
		end else begin
			end_trk = end_m1[cds_pkg::TRACK_BITS-1:0];
		end
	end

	always_comb begin
		q_push          = 1'b0;
		q_data.track    = rd;
		q_data.is_end   = 1'b0;
		q_data.last     = 1'b0;
		q_data.overflow = ovf_q;
		case (state_q)
			PASS1: begin
				q_push = !q_full && (idx_q != count_q) && (rd >= cfg.start_position);
			end
			DEND: begin
				q_push        = !q_full;
				q_data.track  = end_trk;
				q_data.is_end = 1'b1;
				q_data.last   = (lo_q == '0);
			end
			PASS2: begin
				q_push      = !q_full;
				q_data.last = (idx_q == lo_q - cds_pkg::CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && !store_full) begin
			for (int j = 0; j < cds_pkg::MAX_REQUESTS; j++) begin
				if (wr[j]) begin
					store_q[j] <= nxt[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			count_q <= '0;
			idx_q   <= '0;
			lo_q    <= '0;
			drop_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (accept) begin
						if (store_full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + cds_pkg::CNT_W'(1);
						end
						if (in_data.last_request) begin
							state_q <= PASS1;
							idx_q   <= '0;
							lo_q    <= '0;
							ovf_q   <= drop_q || store_full;
						end
					end
				end
				PASS1: begin
					if (!q_full) begin
						if (idx_q == count_q) begin
							state_q <= DEND;
						end else begin
							if (rd < cfg.start_position) begin
								lo_q <= lo_q + cds_pkg::CNT_W'(1);
							end
							idx_q <= idx_q + cds_pkg::CNT_W'(1);
						end
					end
				end
				DEND: begin
					if (!q_full) begin
						idx_q <= '0;
						if (lo_q == '0) begin
							state_q <= LOAD;
							count_q <= '0;
							drop_q  <= 1'b0;
						end else begin
							state_q <= PASS2;
						end
					end
				end
				PASS2: begin
					if (!q_full) begin
						if (idx_q == lo_q - cds_pkg::CNT_W'(1)) begin
							state_q <= LOAD;
							count_q <= '0;
							drop_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + cds_pkg::CNT_W'(1);
						end
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/cds_fifo.sv
// cds_fifo: short queue of visits between the order walk and the movement stage
// depends on cds_pkg
module cds_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cds_pkg::qent_t din,
	output logic           full,
	input  logic           pop,
	output cds_pkg::qent_t dout,
	output logic           empty
);

	cds_pkg::qent_t             mem_q [cds_pkg::QDEPTH];
	logic [cds_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [cds_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [cds_pkg::QPTR_W:0]   cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign full    = (cnt_q == (cds_pkg::QPTR_W+1)'(cds_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + cds_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + cds_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (cds_pkg::QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (cds_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/cds_back.sv
// cds_back: head movement accumulation, seek time and the output register
// depends on cds_pkg; pops visits from cds_fifo
module cds_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cds_pkg::cfg_t  cfg,
	output logic           q_pop,
	input  cds_pkg::qent_t q_data,
	input  logic           q_empty,
	output logic           out_valid,
	input  logic           out_stall,
	output cds_pkg::res_t  out_data
);

	logic                           out_valid_q;
	logic                           first_q;
	logic [cds_pkg::TRACK_BITS-1:0] pos_q;
	logic [cds_pkg::MOVE_W-1:0]     total_q;
	cds_pkg::res_t                  out_q;

	logic                           take;
	logic [cds_pkg::TRACK_BITS-1:0] pos_cur;
	logic [cds_pkg::MOVE_W-1:0]     tot_cur;
	logic [cds_pkg::TRACK_BITS-1:0] gap;
	logic [cds_pkg::MOVE_W:0]       sum;
	logic [cds_pkg::MOVE_W-1:0]     sum_sat;
	logic [cds_pkg::SEEK_W-1:0]     seek;

	assign take      = !q_empty && (!out_valid_q || !out_stall);
	assign q_pop     = take;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		pos_cur = first_q ? cfg.start_position[cds_pkg::TRACK_BITS-1:0] : pos_q;
		tot_cur = first_q ? '0 : total_q;
		gap     = (pos_cur > q_data.track) ? pos_cur - q_data.track : q_data.track - pos_cur;
		sum     = (cds_pkg::MOVE_W+1)'(tot_cur) + (cds_pkg::MOVE_W+1)'(gap);
		sum_sat = sum[cds_pkg::MOVE_W] ? cds_pkg::MOVE_MAX : sum[cds_pkg::MOVE_W-1:0];
		seek    = cds_pkg::SEEK_W'(sum_sat) * cds_pkg::SEEK_W'(cfg.seek_per_track);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.served_track   <= 12'(q_data.track);
			out_q.is_disk_end    <= q_data.is_end;
			out_q.total_movement <= q_data.last ? sum_sat : '0;
			out_q.seek_time      <= q_data.last ? seek : '0;
			out_q.overflow       <= q_data.overflow;
			out_q.final_item     <= q_data.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			first_q     <= 1'b1;
			pos_q       <= '0;
			total_q     <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				first_q     <= q_data.last;
				pos_q       <= q_data.track;
				total_q     <= sum_sat;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/cscan_disk_request_scheduler.sv
// cscan_disk_request_scheduler: top level with configuration registers
// depends on cds_pkg, cds_front, cds_fifo and cds_back
//
// Requests enter on the in channel (in_valid, in_stall, in_data), one per
// cycle, and are inserted into a sorted store of 16 entries; extra requests
// are dropped and flag overflow on every visit of that batch. A request with
// last_request set closes the batch: the in channel then stalls while the
// store is walked in c-scan order. Visits flow through a 4-entry queue to
// the movement stage and leave on the out channel (out_valid, out_stall,
// out_data), at most one per cycle. The final visit carries total_movement
// and seek_time. A stalled out channel holds its item and fills the queue,
// which then pauses the walk. Reset empties the store and queue and loads
// start_position 0, disk_tracks 200, seek_per_track 5. Registers sit at
// byte addresses 0, 4 and 8 of the apb port; the user must write them only
// while no batch is in flight, as the block itself does not enforce this.
module cscan_disk_request_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  cds_pkg::req_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output cds_pkg::res_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cds_pkg::ADDR_W-1:0]  paddr,
	input  logic [cds_pkg::DATA_W-1:0]  pwdata,
	output logic [cds_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	cds_pkg::cfg_t  cfg_q;
	cds_pkg::qent_t push_data;
	cds_pkg::qent_t pop_data;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_position <= 12'd0;
			cfg_q.disk_tracks    <= cds_pkg::DISK_W'(200);
			cfg_q.seek_per_track <= cds_pkg::SPT_W'(5);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				cds_pkg::REG_START_POSITION: cfg_q.start_position <= pwdata[11:0];
				cds_pkg::REG_DISK_TRACKS:    cfg_q.disk_tracks <= pwdata[cds_pkg::DISK_W-1:0];
				cds_pkg::REG_SEEK_PER_TRACK: cfg_q.seek_per_track <= pwdata[cds_pkg::SPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			cds_pkg::REG_START_POSITION: prdata = cds_pkg::DATA_W'(cfg_q.start_position);
			cds_pkg::REG_DISK_TRACKS:    prdata = cds_pkg::DATA_W'(cfg_q.disk_tracks);
			cds_pkg::REG_SEEK_PER_TRACK: prdata = cds_pkg::DATA_W'(cfg_q.seek_per_track);
			default:                     prdata = '0;
		endcase
	end

	cds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_push   (push),
		.q_data   (push_data),
		.q_full   (q_full)
	);

	cds_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (q_full),
		.pop    (pop),
		.dout   (pop_data),
		.empty  (q_empty)
	);

	cds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_pop     (pop),
		.q_data    (pop_data),
		.q_empty   (q_empty),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
